[design/rvs_pkg.sv]
`default_nettype none

package rvs_pkg;

  localparam int unsigned MaxPairs = 1024;
  localparam int unsigned SlotW    = $clog2(MaxPairs);

  localparam logic [63:0] DblOne        = 64'h3FF0000000000000;
  localparam logic [63:0] DblSix        = 64'h4018000000000000;
  localparam logic [63:0] DblNan        = 64'h7FF8000000000000;
  localparam logic [63:0] DblFiveSixths = 64'h3FEAAAAAAAAAAAAB;
  localparam logic [31:0] SglNan        = 32'h7FC00000;

  typedef enum logic [1:0] {
    FpuAdd = 2'd0,
    FpuMul = 2'd1,
    FpuDiv = 2'd2
  } fpu_op_e;

  typedef struct packed {
    logic [31:0] inst_distance;
    logic [31:0] avg_inv_cube;
    logic [9:0]  pair_number;
    logic        accumulate_enable;
    logic [31:0] group_bound;
    logic        last_in_group;
    logic        last_in_frame;
  } in_t;

  typedef struct packed {
    logic [31:0] pair_accum_value;
    logic        group_valid;
    logic [31:0] inst_violation;
    logic [31:0] avg_violation;
    logic [31:0] total_inst;
    logic [31:0] total_avg;
    logic        frame_done;
  } out_t;

  // seeds of the inverse sixth root, 2^(-r/6)
  function automatic logic [63:0] root_seed(input logic [2:0] r);
    logic [63:0] v;
    case (r)
      3'd1:    v = $realtobits(0.8908987181403393);
      3'd2:    v = $realtobits(0.7937005259840998);
      3'd3:    v = $realtobits(0.7071067811865476);
      3'd4:    v = $realtobits(0.6299605249474366);
      3'd5:    v = $realtobits(0.5612310241546865);
      default: v = DblOne;
    endcase
    return v;
  endfunction

  // single to double, exact
  function automatic logic [63:0] from_sgl(input logic [31:0] f);
    logic [63:0] d;
    logic [4:0]  p;
    logic [51:0] m;
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) p = 5'(i);
    end
    m = 52'({29'b0, f[22:0]} << (6'd52 - {1'b0, p}));
    if (f[30:23] == 8'hFF) begin
      d = {f[31], 11'h7FF, f[22:0], 29'b0};
    end else if (f[30:23] != 8'h00) begin
      d = {f[31], 11'({3'b0, f[30:23]} + 11'd896), f[22:0], 29'b0};
    end else if (f[22:0] == 23'd0) begin
      d = {f[31], 63'b0};
    end else begin
      d = {f[31], 11'({6'b0, p} + 11'd874), m};
    end
    return d;
  endfunction

  // double to single, round to nearest even, nan made canonical
  function automatic logic [31:0] to_sgl(input logic [63:0] d);
    logic [31:0]        s;
    logic signed [12:0] e;
    logic signed [12:0] sh;
    logic [116:0]       ext;
    logic               inc;
    e = $signed({2'b00, d[62:52]}) - 13'sd1023;
    sh = -e - 13'sd97;
    ext = {1'b1, d[51:0], 64'b0} >> sh[6:0];
    if (d[62:52] == 11'h7FF) begin
      s = (d[51:0] != 52'd0) ? SglNan : {d[63], 8'hFF, 23'b0};
    end else if (d[62:52] == 11'd0) begin
      s = {d[63], 31'b0};
    end else if (e > 13'sd127) begin
      s = {d[63], 8'hFF, 23'b0};
    end else if (e >= -13'sd126) begin
      inc = d[28] & ((|d[27:0]) | d[29]);
      s = {d[63], 8'(e + 13'sd127), d[51:29]} + {31'b0, inc};
    end else if (sh > 13'sd54) begin
      s = {d[63], 31'b0};
    end else begin
      inc = ext[63] & ((|ext[62:0]) | ext[64]);
      s = {d[63], 31'({8'b0, ext[86:64]} + {30'b0, inc})};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[design/rvs_fpu.sv]
`default_nettype none

module rvs_fpu
  import rvs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fpu_op_e     op_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  typedef enum logic [3:0] {
    FIdle = 4'b0001,
    FMul  = 4'b0010,
    FDiv  = 4'b0100,
    FNorm = 4'b1000
  } fst_e;

  typedef struct packed {
    logic               s;
    logic               zero;
    logic               inf;
    logic               nan;
    logic signed [12:0] e;
    logic [52:0]        m;
  } unp_t;

  function automatic unp_t unpack(input logic [63:0] d);
    unp_t u;
    u.s    = d[63];
    u.zero = (d[62:52] == 11'd0);
    u.inf  = (d[62:52] == 11'h7FF) && (d[51:0] == 52'd0);
    u.nan  = (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
    u.e    = $signed({2'b00, d[62:52]}) - 13'sd1023;
    u.m    = {1'b1, d[51:0]};
    return u;
  endfunction

  fst_e               fst_q;
  logic               done_q;
  logic [63:0]        res_q;
  logic [59:0]        rm_q;
  logic signed [12:0] re_q;
  logic               rs_q;
  logic               st_q;
  logic [52:0]        ma_q;
  logic [52:0]        mb_q;
  logic [105:0]       acc_q;
  logic [53:0]        pp_q;
  logic [6:0]         psh_q;
  logic [5:0]         cnt_q;
  logic [53:0]        rem_q;

  unp_t        ua, ub, ubig, usml;
  logic        spec;
  logic [63:0] spec_res;
  logic [12:0] dexp;
  logic [58:0] sm, shifted;
  logic        lost;
  logic [59:0] bm, sml, sum;
  logic [26:0] mx, my;
  logic [6:0]  psh;
  logic        div_ge;
  logic [53:0] div_rem;
  logic [52:0] mant;
  logic        rinc;
  logic [53:0] mr;
  logic signed [13:0] biased;
  logic [63:0] packed_res;

  // operand decode and special values
  always_comb begin
    ua = unpack(a_i);
    ub = unpack(b_i);
    spec = 1'b1;
    spec_res = '0;
    unique case (op_i)
      FpuAdd: begin
        if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.s != ub.s))) spec_res = DblNan;
        else if (ua.inf) spec_res = a_i;
        else if (ub.inf) spec_res = b_i;
        else if (ua.zero && ub.zero) spec_res = {ua.s & ub.s, 63'b0};
        else if (ua.zero) spec_res = b_i;
        else if (ub.zero) spec_res = a_i;
        else spec = 1'b0;
      end
      FpuMul: begin
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) spec_res = DblNan;
        else if (ua.inf || ub.inf) spec_res = {ua.s ^ ub.s, 11'h7FF, 52'b0};
        else if (ua.zero || ub.zero) spec_res = {ua.s ^ ub.s, 63'b0};
        else spec = 1'b0;
      end
      FpuDiv: begin
        if (ua.nan || ub.nan || (ua.zero && ub.zero) || (ua.inf && ub.inf)) spec_res = DblNan;
        else if (ua.inf || ub.zero) spec_res = {ua.s ^ ub.s, 11'h7FF, 52'b0};
        else if (ua.zero || ub.inf) spec_res = {ua.s ^ ub.s, 63'b0};
        else spec = 1'b0;
      end
      default: spec_res = DblNan;
    endcase
  end

  // add alignment with sticky jam
  always_comb begin
    if (a_i[62:0] >= b_i[62:0]) begin
      ubig = ua;
      usml = ub;
    end else begin
      ubig = ub;
      usml = ua;
    end
    dexp = 13'(ubig.e - usml.e);
    sm = {usml.m, 6'b0};
    if (dexp >= 13'd59) begin
      shifted = '0;
      lost = 1'b1;
    end else begin
      shifted = sm >> dexp;
      lost = ((shifted << dexp) != sm);
    end
    bm = {1'b0, ubig.m, 6'b0};
    sml = {1'b0, shifted | {58'b0, lost}};
    sum = (ua.s != ub.s) ? (bm - sml) : (bm + sml);
  end

  // partial product select
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin mx = ma_q[26:0];          my = mb_q[26:0];          psh = 7'd0;  end
      2'd1: begin mx = ma_q[26:0];          my = {1'b0, mb_q[52:27]}; psh = 7'd27; end
      2'd2: begin mx = {1'b0, ma_q[52:27]}; my = mb_q[26:0];          psh = 7'd27; end
      default: begin
        mx = {1'b0, ma_q[52:27]};
        my = {1'b0, mb_q[52:27]};
        psh = 7'd54;
      end
    endcase
  end

  assign div_ge  = (rem_q >= {1'b0, mb_q});
  assign div_rem = div_ge ? (rem_q - {1'b0, mb_q}) : rem_q;

  // round and pack
  always_comb begin
    mant = rm_q[58:6];
    rinc = rm_q[5] & ((|rm_q[4:0]) | st_q | mant[0]);
    mr = {1'b0, mant} + {53'b0, rinc};
    biased = 14'(re_q) + 14'sd1023 + (mr[53] ? 14'sd1 : 14'sd0);
    if (biased >= 14'sd2047) packed_res = {rs_q, 11'h7FF, 52'b0};
    else if (biased <= 14'sd0) packed_res = {rs_q, 63'b0};
    else packed_res = {rs_q, 11'(biased), mr[53] ? 52'b0 : mr[51:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q  <= FIdle;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (fst_q)
        FIdle: begin
          if (start_i) begin
            if (spec) begin
              res_q  <= spec_res;
              done_q <= 1'b1;
            end else begin
              case (op_i)
                FpuAdd: begin
                  rm_q  <= sum;
                  re_q  <= ubig.e;
                  rs_q  <= ubig.s;
                  st_q  <= 1'b0;
                  fst_q <= FNorm;
                end
                FpuMul: begin
                  ma_q  <= ua.m;
                  mb_q  <= ub.m;
                  re_q  <= ua.e + ub.e;
                  rs_q  <= ua.s ^ ub.s;
                  acc_q <= '0;
                  cnt_q <= '0;
                  fst_q <= FMul;
                end
                default: begin
                  rem_q <= {1'b0, ua.m};
                  mb_q  <= ub.m;
                  re_q  <= ua.e - ub.e;
                  rs_q  <= ua.s ^ ub.s;
                  rm_q  <= '0;
                  cnt_q <= '0;
                  fst_q <= FDiv;
                end
              endcase
            end
          end
        end
        FMul: begin
          // one 27x27 product a cycle, accumulated the cycle after
          pp_q  <= 54'(mx) * 54'(my);
          psh_q <= psh;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q != 6'd0 && cnt_q <= 6'd4) begin
            acc_q <= acc_q + (106'(pp_q) << psh_q);
          end
          if (cnt_q == 6'd5) begin
            rm_q  <= acc_q[105:46];
            st_q  <= |acc_q[45:0];
            fst_q <= FNorm;
          end
        end
        FDiv: begin
          // restoring, one quotient bit a cycle
          rm_q  <= {rm_q[58:0], div_ge};
          rem_q <= {div_rem[52:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd58) begin
            st_q  <= (div_rem != 54'd0);
            fst_q <= FNorm;
          end
        end
        FNorm: begin
          if (rm_q == 60'd0) begin
            res_q  <= 64'd0;
            done_q <= 1'b1;
            fst_q  <= FIdle;
          end else if (rm_q[59]) begin
            rm_q <= rm_q >> 1;
            st_q <= st_q | rm_q[0];
            re_q <= re_q + 13'sd1;
          end else if (!rm_q[58]) begin
            rm_q <= rm_q << 1;
            re_q <= re_q - 13'sd1;
          end else begin
            res_q  <= packed_res;
            done_q <= 1'b1;
            fst_q  <= FIdle;
          end
        end
        default: fst_q <= FIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[design/restraint_r6_violation_sum_core.sv]
// a group end adds two inverse sixth roots, of 8 newton steps each, to the work of a beat
// throughput: one beat at a time, set by the shared double unit
// reset: control clears at once, then a clearing pass zeroes the pair store
//   while in_stall_o stays high
`default_nettype none

module restraint_r6_violation_sum_core
  import rvs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // sequencer, one fpu operation per state
  typedef enum logic [24:0] {
    SClr  = 25'h0000001,
    SIdle = 25'h0000002,
    SCb1  = 25'h0000004,
    SCb2  = 25'h0000008,
    SRcp  = 25'h0000010,
    SAcc  = 25'h0000020,
    SSq6  = 25'h0000040,
    SGad  = 25'h0000080,
    SAsq  = 25'h0000100,
    SAad  = 25'h0000200,
    SRset = 25'h0000400,
    SY2   = 25'h0000800,
    SY3   = 25'h0001000,
    SY4   = 25'h0002000,
    SY5   = 25'h0004000,
    STz   = 25'h0008000,
    STt   = 25'h0010000,
    SDv   = 25'h0020000,
    SUu   = 25'h0040000,
    SNa   = 25'h0080000,
    SSc   = 25'h0100000,
    SSb   = 25'h0200000,
    STa1  = 25'h0400000,
    STa2  = 25'h0800000,
    SFin  = 25'h1000000
  } state_e;

  state_e           state_q;
  logic [SlotW-1:0] clr_q;
  logic             busy_q;
  logic             out_valid_q;
  out_t             out_q;
  in_t              in_q;

  // per-pair r^-3 sums
  logic [31:0] pair_mem [MaxPairs];
  logic [31:0] mem_rd_q;
  logic        mem_we;
  logic [SlotW-1:0] mem_wa;
  logic [31:0] mem_wd;

  // single-precision state
  logic [31:0] ig_q, ag_q, ti_q, ta_q, iv_q, av_q, pv_q;
  // double working registers
  logic [63:0] p3_q, t_q, w_q, y_q, z_q, d_q;
  logic [10:0] sc_exp_q;
  logic [2:0]  it_q;
  logic        avg_sel_q;

  logic        fpu_use, fpu_start, fpu_done;
  fpu_op_e     fpu_op;
  logic [63:0] fpu_a, fpu_b, fpu_res;

  logic        accept;
  logic [63:0] r_d, a_d, b_d, x_d;
  logic        r_pos, x_pos, v_pos;
  logic [11:0] ee, rem_w;
  logic [25:0] quo_p;
  logic [8:0]  quo;
  logic [2:0]  rsel;
  logic [31:0] clamp_sgl;
  state_e      after_p3;

  assign accept = in_valid_i && (state_q == SIdle);

  assign r_d = from_sgl(in_q.inst_distance);
  assign a_d = from_sgl(in_q.avg_inv_cube);
  assign b_d = from_sgl(in_q.group_bound);
  assign x_d = from_sgl(avg_sel_q ? ag_q : ig_q);

  // r^-3 only for a positive finite distance
  assign r_pos = !r_d[63] && (r_d[62:52] != 11'd0) && (r_d[62:52] != 11'h7FF);
  assign x_pos = !x_d[63] && (x_d[62:52] != 11'd0) && (x_d[62:52] != 11'h7FF);

  // root range reduction: ee = e + 1200, split by six
  assign ee    = {1'b0, x_d[62:52]} + 12'd177;
  assign quo_p = 26'(ee) * 26'd10923;
  assign quo   = quo_p[24:16];
  assign rem_w = ee - (12'(quo) * 12'd6);
  assign rsel  = rem_w[2:0];

  // violation clamp: nan or not above zero gives +0
  assign v_pos = !fpu_res[63] && (fpu_res[62:0] != 63'd0)
                 && !((fpu_res[62:52] == 11'h7FF) && (fpu_res[51:0] != 52'd0));
  assign clamp_sgl = v_pos ? to_sgl(fpu_res) : 32'd0;

  assign after_p3 = in_q.accumulate_enable ? SAcc : SSq6;

  // operand steering
  always_comb begin
    fpu_use = 1'b1;
    fpu_op  = FpuMul;
    fpu_a   = '0;
    fpu_b   = '0;
    unique case (state_q)
      SCb1: begin fpu_use = r_pos; fpu_a = r_d; fpu_b = r_d; end
      SCb2: begin fpu_a = t_q; fpu_b = r_d; end
      SRcp: begin fpu_op = FpuDiv; fpu_a = DblOne; fpu_b = t_q; end
      SAcc: begin fpu_op = FpuAdd; fpu_a = from_sgl(mem_rd_q); fpu_b = p3_q; end
      SSq6: begin fpu_a = p3_q; fpu_b = p3_q; end
      SGad: begin fpu_op = FpuAdd; fpu_a = from_sgl(ig_q); fpu_b = t_q; end
      SAsq: begin fpu_a = a_d; fpu_b = a_d; end
      SAad: begin fpu_op = FpuAdd; fpu_a = from_sgl(ag_q); fpu_b = t_q; end
      SY2:  begin fpu_a = y_q; fpu_b = y_q; end
      SY3, SY4, SY5: begin fpu_a = w_q; fpu_b = y_q; end
      STz:  begin fpu_a = DblSix; fpu_b = z_q; end
      STt:  begin fpu_a = t_q; fpu_b = w_q; end
      SDv:  begin fpu_op = FpuDiv; fpu_a = DblOne; fpu_b = t_q; end
      SUu:  begin fpu_a = y_q; fpu_b = DblFiveSixths; end
      SNa:  begin fpu_op = FpuAdd; fpu_a = w_q; fpu_b = d_q; end
      SSc:  begin fpu_a = y_q; fpu_b = {1'b0, sc_exp_q, 52'b0}; end
      SSb:  begin fpu_op = FpuAdd; fpu_a = y_q; fpu_b = {~b_d[63], b_d[62:0]}; end
      STa1: begin fpu_op = FpuAdd; fpu_a = from_sgl(ti_q); fpu_b = from_sgl(iv_q); end
      STa2: begin fpu_op = FpuAdd; fpu_a = from_sgl(ta_q); fpu_b = from_sgl(av_q); end
      default: fpu_use = 1'b0;
    endcase
  end

  assign fpu_start = fpu_use && !busy_q;

  rvs_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fpu_start),
    .op_i    (fpu_op),
    .a_i     (fpu_a),
    .b_i     (fpu_b),
    .done_o  (fpu_done),
    .res_o   (fpu_res)
  );

  // store write port: clearing pass or pair update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = 32'd0;
    if (state_q == SClr) begin
      mem_we = 1'b1;
    end else if (state_q == SAcc && fpu_done) begin
      mem_we = 1'b1;
      mem_wa = in_q.pair_number[SlotW-1:0];
      mem_wd = to_sgl(fpu_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) pair_mem[mem_wa] <= mem_wd;
    if (accept) mem_rd_q <= pair_mem[in_data_i.pair_number[SlotW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ig_q        <= '0;
      ag_q        <= '0;
      ti_q        <= '0;
      ta_q        <= '0;
      avg_sel_q   <= 1'b0;
      it_q        <= '0;
    end else begin
      if (fpu_start) busy_q <= 1'b1;
      else if (fpu_done) busy_q <= 1'b0;

      // the result state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != SFin)) out_valid_q <= 1'b0;

      unique case (state_q)
        SClr: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= SIdle;
        end
        SIdle: begin
          if (accept) begin
            in_q    <= in_data_i;
            iv_q    <= '0;
            av_q    <= '0;
            state_q <= SCb1;
          end
        end
        SCb1: begin
          if (!r_pos) begin
            p3_q    <= '0;
            pv_q    <= mem_rd_q;
            state_q <= after_p3;
          end else if (fpu_done) begin
            t_q     <= fpu_res;
            state_q <= SCb2;
          end
        end
        SCb2: if (fpu_done) begin t_q <= fpu_res; state_q <= SRcp; end
        SRcp: begin
          if (fpu_done) begin
            p3_q    <= fpu_res;
            pv_q    <= mem_rd_q;
            state_q <= after_p3;
          end
        end
        SAcc: if (fpu_done) begin pv_q <= to_sgl(fpu_res); state_q <= SSq6; end
        SSq6: if (fpu_done) begin t_q <= fpu_res; state_q <= SGad; end
        SGad: if (fpu_done) begin ig_q <= to_sgl(fpu_res); state_q <= SAsq; end
        SAsq: if (fpu_done) begin t_q <= fpu_res; state_q <= SAad; end
        SAad: begin
          if (fpu_done) begin
            ag_q      <= to_sgl(fpu_res);
            avg_sel_q <= 1'b0;
            state_q   <= in_q.last_in_group ? SRset : SFin;
          end
        end
        SRset: begin
          // no root of a nonpositive or non-finite sum
          if (!x_pos) begin
            y_q     <= '0;
            state_q <= SSb;
          end else begin
            z_q      <= {1'b0, 11'd1023 + {8'b0, rsel}, x_d[51:0]};
            y_q      <= root_seed(rsel);
            sc_exp_q <= 11'(12'd1223 - {3'b0, quo});
            it_q     <= '0;
            state_q  <= SY2;
          end
        end
        SY2: if (fpu_done) begin w_q <= fpu_res; state_q <= SY3; end
        SY3: if (fpu_done) begin w_q <= fpu_res; state_q <= SY4; end
        SY4: if (fpu_done) begin w_q <= fpu_res; state_q <= SY5; end
        SY5: if (fpu_done) begin w_q <= fpu_res; state_q <= STz; end
        STz: if (fpu_done) begin t_q <= fpu_res; state_q <= STt; end
        STt: if (fpu_done) begin t_q <= fpu_res; state_q <= SDv; end
        SDv: if (fpu_done) begin d_q <= fpu_res; state_q <= SUu; end
        SUu: if (fpu_done) begin w_q <= fpu_res; state_q <= SNa; end
        SNa: begin
          // y = y*5/6 + 1/(6 z y^5)
          if (fpu_done) begin
            y_q     <= fpu_res;
            it_q    <= it_q + 3'd1;
            state_q <= (&it_q) ? SSc : SY2;
          end
        end
        SSc: if (fpu_done) begin y_q <= fpu_res; state_q <= SSb; end
        SSb: begin
          if (fpu_done) begin
            if (!avg_sel_q) begin
              iv_q      <= clamp_sgl;
              avg_sel_q <= 1'b1;
              state_q   <= SRset;
            end else begin
              av_q    <= clamp_sgl;
              state_q <= STa1;
            end
          end
        end
        STa1: if (fpu_done) begin ti_q <= to_sgl(fpu_res); state_q <= STa2; end
        STa2: if (fpu_done) begin ta_q <= to_sgl(fpu_res); state_q <= SFin; end
        SFin: begin
          // result beat waits here until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.pair_accum_value <= pv_q;
            out_q.group_valid      <= in_q.last_in_group;
            out_q.inst_violation   <= iv_q;
            out_q.avg_violation    <= av_q;
            out_q.total_inst       <= ti_q;
            out_q.total_avg        <= ta_q;
            out_q.frame_done       <= in_q.last_in_frame;
            out_valid_q            <= 1'b1;
            if (in_q.last_in_group) begin
              ig_q <= '0;
              ag_q <= '0;
            end
            if (in_q.last_in_frame) begin
              ti_q <= '0;
              ta_q <= '0;
            end
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[dv/rvs_checker.sv]
module rvs_checker
  import rvs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] DblTopBits = 64'h7FEFFFFFFFFFFFFF;

  logic [31:0] pair_r3_store [MaxPairs];
  logic [31:0] grp_r6_sum, grp_avg_sq_sum, frame_inst_total, frame_avg_total;
  out_t        violation_q [$];

  function automatic real pow2_of(input int k);
    return $bitstoreal({1'b0, 11'(1023 + k), 52'b0});
  endfunction

  // single bits widened to double, exact
  function automatic real widen(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'hFF) begin
      return (f[22:0] != 0) ? $bitstoreal(64'h7FF8000000000000)
                            : $bitstoreal({f[31], 11'h7FF, 52'b0});
    end
    if (f[30:23] != 8'h00) return $bitstoreal({f[31], 11'(f[30:23] + 896), f[22:0], 29'b0});
    v = real'(f[22:0]) * pow2_of(-149);
    return f[31] ? -v : v;
  endfunction

  // double narrowed to single, round to nearest even
  function automatic logic [31:0] narrow(input real d);
    logic [63:0]  b;
    int           e;
    int           sh;
    logic [116:0] ext;
    logic         inc;
    logic [31:0]  s;
    b = $realtobits(d);
    if (b[62:52] == 11'h7FF) begin
      s = (b[51:0] != 0) ? SglNan : {b[63], 8'hFF, 23'b0};
    end else if (b[62:52] == 11'h000) begin
      s = {b[63], 31'b0};
    end else begin
      e = int'(b[62:52]) - 1023;
      if (e > 127) begin
        s = {b[63], 8'hFF, 23'b0};
      end else if (e >= -126) begin
        inc = b[28] & ((|b[27:0]) | b[29]);
        s = {b[63], 8'(e + 127), b[51:29]} + {31'b0, inc};
      end else begin
        sh = -e - 97;
        if (sh > 60) begin
          s = {b[63], 31'b0};
        end else begin
          ext = {1'b1, b[51:0], 64'b0} >> sh;
          inc = ext[63] & ((|ext[62:0]) | ext[64]);
          s = {b[63], 31'(ext[86:64]) + {30'b0, inc}};
        end
      end
    end
    return s;
  endfunction

  function automatic real inv_cube_of(input real x);
    if (!(x > 0.0) || x > $bitstoreal(DblTopBits)) return 0.0;
    return 1.0 / (x * x * x);
  endfunction

  // newton iteration on z^(-1/6), z scaled into [1,64)
  function automatic real inv_sixth_root_of(input real x);
    logic [63:0] b;
    int          e, ee, q, r;
    real         z, y, y5, post;
    post = 1.0;
    if (!(x > 0.0) || x > $bitstoreal(DblTopBits)) return 0.0;
    b = $realtobits(x);
    if (b[62:52] == 11'h000) begin
      x = x * pow2_of(600);
      post = pow2_of(100);
      b = $realtobits(x);
    end
    e = int'(b[62:52]) - 1023;
    ee = e + 1200;
    q = ee / 6 - 200;
    r = ee % 6;
    z = $bitstoreal({1'b0, 11'(1023 + r), b[51:0]});
    case (r)
      1:       y = 0.8908987181403393;
      2:       y = 0.7937005259840998;
      3:       y = 0.7071067811865476;
      4:       y = 0.6299605249474366;
      5:       y = 0.5612310241546865;
      default: y = 1.0;
    endcase
    for (int i = 0; i < 8; i++) begin
      y5 = y * y * y * y * y;
      y = y * (5.0 / 6.0) + 1.0 / (6.0 * z * y5);
    end
    return y * pow2_of(-q) * post;
  endfunction

  function automatic real clamp_pos(input real v);
    return (v > 0.0) ? v : 0.0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = violation_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned slot;
    real         r3, bound;
    out_t        res, got;
    if (!rst_ni) begin
      foreach (pair_r3_store[i]) pair_r3_store[i] = '0;
      grp_r6_sum = '0;
      grp_avg_sq_sum = '0;
      frame_inst_total = '0;
      frame_avg_total = '0;
      fail_count_o = 0;
      violation_q.delete();
    end else begin
      // accepted input beat: advance the predicted state
      if (in_valid_i && !in_stall_i) begin
        slot = in_data_i.pair_number % MaxPairs;
        r3 = inv_cube_of(widen(in_data_i.inst_distance));
        if (in_data_i.accumulate_enable)
          pair_r3_store[slot] = narrow(widen(pair_r3_store[slot]) + r3);
        grp_r6_sum = narrow(widen(grp_r6_sum) + r3 * r3);
        grp_avg_sq_sum = narrow(widen(grp_avg_sq_sum) +
                                widen(in_data_i.avg_inv_cube) * widen(in_data_i.avg_inv_cube));
        res = '0;
        if (in_data_i.last_in_group) begin
          bound = widen(in_data_i.group_bound);
          res.inst_violation = narrow(clamp_pos(inv_sixth_root_of(widen(grp_r6_sum)) - bound));
          res.avg_violation = narrow(clamp_pos(inv_sixth_root_of(widen(grp_avg_sq_sum)) - bound));
          frame_inst_total = narrow(widen(frame_inst_total) + widen(res.inst_violation));
          frame_avg_total = narrow(widen(frame_avg_total) + widen(res.avg_violation));
          grp_r6_sum = '0;
          grp_avg_sq_sum = '0;
        end
        res.pair_accum_value = pair_r3_store[slot];
        res.group_valid = in_data_i.last_in_group;
        res.total_inst = frame_inst_total;
        res.total_avg = frame_avg_total;
        res.frame_done = in_data_i.last_in_frame;
        if (in_data_i.last_in_frame) begin
          frame_inst_total = '0;
          frame_avg_total = '0;
        end
        violation_q.push_back(res);
      end
      // accepted output beat: compare against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (violation_q.size() == 0) begin
          $error("unexpected output beat %h", got);
          fail_count_o++;
        end else begin
          res = violation_q.pop_front();
          check_field("pair_accum_value", res.pair_accum_value, got.pair_accum_value);
          check_field("group_valid", 32'(res.group_valid), 32'(got.group_valid));
          check_field("inst_violation", res.inst_violation, got.inst_violation);
          check_field("avg_violation", res.avg_violation, got.avg_violation);
          check_field("total_inst", res.total_inst, got.total_inst);
          check_field("total_avg", res.total_avg, got.total_avg);
          check_field("frame_done", 32'(res.frame_done), 32'(got.frame_done));
        end
      end
    end
  end

endmodule

[dv/tb.sv]
module tb;
  import rvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound covering the group closes and the store clear
  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned RandomBeats = 630;
  localparam int unsigned LongHold = 6000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;

  int unsigned fail_count, pending;
  int unsigned beats_sent, groups_sent, frames_sent, cycles;

  // stimulus mode flags shared with the receiver process
  bit calm;       // final stretch, no idling on either side
  bit quiet;      // short stretches with no idling
  bit hold_req;   // ask the receiver for one long hold-off

  restraint_r6_violation_sum_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  rvs_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on total cycles
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
        $display("[restraint_r6_violation_sum_core] ERROR");
        $finish;
      end
    end
  end

  function automatic in_t make_beat(input logic [31:0] distance, input logic [31:0] avg,
                                    input logic [9:0] slot, input logic acc,
                                    input logic [31:0] bound, input logic lg,
                                    input logic lf);
    in_t b;
    b.inst_distance = distance;
    b.avg_inv_cube = avg;
    b.pair_number = slot;
    b.accumulate_enable = acc;
    b.group_bound = bound;
    b.last_in_group = lg;
    b.last_in_frame = lf;
    return b;
  endfunction

  // mostly plausible magnitudes, sometimes specials or raw bits
  function automatic logic [31:0] pick_float(input int lo, input int hi);
    logic [31:0] f;
    case ($urandom_range(0, 19))
      0: f = $urandom;
      1: begin
        case ($urandom_range(0, 7))
          0: f = 32'h00000000;
          1: f = 32'h80000000;
          2: f = 32'h7F800000;
          3: f = 32'hFF800000;
          4: f = {1'b0, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
          5: f = {1'b0, 8'h00, 23'($urandom)};
          6: f = {1'b0, 8'h01, 23'($urandom)};
          default: f = {1'b0, 8'hFE, 23'($urandom)};
        endcase
      end
      2: f = {1'b1, 8'($urandom_range(lo, hi)), 23'($urandom)};
      default: f = {1'b0, 8'($urandom_range(lo, hi)), 23'($urandom)};
    endcase
    return f;
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_beat(input in_t b);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (b.last_in_group) groups_sent++;
    if (b.last_in_frame) frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    in_t         b;
    int unsigned grp_len, grps_in_frame, grp_cnt;
    logic [9:0]  hot_slot;
    bit          hold_done, drain_done;
    calm = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    beats_sent = 0;
    groups_sent = 0;
    frames_sent = 0;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases
    // zero, negative and nan distances contribute nothing
    send_beat(make_beat(32'h00000000, 32'h3F800000, 10'd0, 1'b1, 32'h00000000, 1'b0, 1'b0));
    send_beat(make_beat(32'hBF800000, 32'h00000000, 10'd0, 1'b1, 32'h00000000, 1'b0, 1'b0));
    send_beat(make_beat(32'h7FC00000, 32'h7FC00000, 10'd1023, 1'b1, 32'h3F000000, 1'b1, 1'b0));
    // infinite distance, nan bound
    send_beat(make_beat(32'h7F800000, 32'h3E800000, 10'd1023, 1'b1, 32'h7FC00000, 1'b1, 1'b0));
    // tiny distance overflows the sums to infinity, root gives zero
    send_beat(make_beat(32'h00800001, 32'h7F7FFFFF, 10'd5, 1'b1, 32'h00000000, 1'b1, 1'b0));
    // subnormal distance, subnormal average
    send_beat(make_beat(32'h00000001, 32'h00000001, 10'd5, 1'b1, 32'hFF800000, 1'b1, 1'b0));
    // huge distance drives r^-6 toward subnormal sums
    send_beat(make_beat(32'h7F7FFFFF, 32'h1E000000, 10'd6, 1'b1, 32'h00000000, 1'b1, 1'b0));
    send_beat(make_beat(32'h4A000000, 32'h21000000, 10'd6, 1'b1, 32'h80000000, 1'b1, 1'b0));
    // plain group of three, accumulation off on one
    send_beat(make_beat(32'h3FC00000, 32'h3E000000, 10'd7, 1'b1, 32'h3F000000, 1'b0, 1'b0));
    send_beat(make_beat(32'h40000000, 32'h3D800000, 10'd7, 1'b0, 32'h3F000000, 1'b0, 1'b0));
    send_beat(make_beat(32'h40200000, 32'h3D000000, 10'd8, 1'b1, 32'h3F000000, 1'b1, 1'b1));
    // frame end without group end: open sums carry over
    send_beat(make_beat(32'h3F800000, 32'h3F800000, 10'd9, 1'b1, 32'h00000000, 1'b0, 1'b1));
    send_beat(make_beat(32'h3F800000, 32'h3F800000, 10'd9, 1'b1, 32'h3F000000, 1'b1, 1'b0));
    // large bound clamps to zero, negative bound raises violation
    send_beat(make_beat(32'h3F800000, 32'h3F800000, 10'd10, 1'b1, 32'h7F7FFFFF, 1'b1, 1'b0));
    send_beat(make_beat(32'h3F800000, 32'h3F800000, 10'd10, 1'b1, 32'hC0000000, 1'b1, 1'b1));
    // all ones on every field, then all zeros but for the group and frame ends
    send_beat(make_beat('1, '1, '1, 1'b1, '1, 1'b1, 1'b1));
    send_beat(make_beat('0, '0, '0, 1'b0, '0, 1'b1, 1'b1));
    send_beat(make_beat(32'h3F000000, 32'h3F000000, 10'd512, 1'b1, 32'h3F000000, 1'b0, 1'b0));
    send_beat(make_beat(32'h3F000000, 32'h3F000000, 10'd512, 1'b1, 32'h3F000000, 1'b1, 1'b1));

    // random: well-formed groups and frames, some raw noise
    grps_in_frame = $urandom_range(1, 4);
    grp_cnt = 0;
    while (beats_sent < 19 + RandomBeats) begin
      if (beats_sent % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (beats_sent >= 19 + RandomBeats - 70) calm = 1'b1;
      // one long receiver hold-off while beats keep coming
      if (!hold_done && beats_sent >= 220) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      // one sender pause until everything has drained
      if (!drain_done && beats_sent >= 420) begin
        wait_drained();
        drain_done = 1'b1;
      end

      if ($urandom_range(0, 9) == 0) begin
        b = make_beat($urandom, $urandom, 10'($urandom), 1'($urandom), $urandom,
                      1'($urandom), 1'($urandom));
        send_beat(b);
      end else begin
        grp_len = $urandom_range(1, 4);
        hot_slot = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
        grp_cnt++;
        for (int i = 0; i < grp_len; i++) begin
          b = make_beat(pick_float(123, 129), pick_float(118, 128),
                        ($urandom_range(0, 2) == 0) ? 10'($urandom) : hot_slot,
                        1'($urandom_range(0, 3) != 0), pick_float(122, 128),
                        1'(i == grp_len - 1), 1'b0);
          b.last_in_frame = (b.last_in_group && grp_cnt >= grps_in_frame) ||
                            ($urandom_range(0, 40) == 0);
          send_beat(b);
        end
        if (grp_cnt >= grps_in_frame) begin
          grp_cnt = 0;
          grps_in_frame = $urandom_range(1, 4);
        end
      end
    end
    wait_drained();
    // let any trailing activity show up
    repeat (2500) @(posedge clk_i);

    $display("sent %0d beats: %0d group closes, %0d frame ends, specials and raw bits",
             beats_sent, groups_sent, frames_sent);
    $display("with stall bursts, one long output hold-off and one full drain");
    if (fail_count == 0 && pending == 0) begin
      $display("[restraint_r6_violation_sum_core] OK");
    end else begin
      $display("[restraint_r6_violation_sum_core] ERROR");
    end
    $finish;
  end

endmodule
